// File: sv/trd_pkg.sv
// types and constants shared by the tga decoder modules
`default_nettype none
package trd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ID_SKIP,
    PH_PACKET,
    PH_PIXEL,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_SPAN,
    JOB_ERROR
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
    logic [15:0] width;
    logic [15:0] height;
  } job_t;

  localparam logic [4:0] HDR_ID_LEN    = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_BPP       = 5'd16;
  localparam logic [4:0] HDR_LAST      = 5'd17;

  localparam logic [7:0] IMG_TRUE_COLOR = 8'd2;
  localparam logic [7:0] IMG_RLE_COLOR  = 8'd10;
  localparam logic [7:0] CMAP_NONE      = 8'd0;
  localparam logic [7:0] BPP_24         = 8'd24;
  localparam logic [7:0] BPP_32         = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'hff;

  localparam logic [1:0] CB_BLUE  = 2'd0;
  localparam logic [1:0] CB_GREEN = 2'd1;
  localparam logic [1:0] CB_RED   = 2'd2;
  localparam logic [1:0] CB_ALPHA = 2'd3;

  localparam logic RES_SPAN  = 1'b0;
  localparam logic RES_ERROR = 1'b1;

endpackage
`default_nettype wire

// File: sv/tga_rle_pixel_decoder_top.sv
// top level of the tga byte stream decoder
`default_nettype none
// Decodes a TGA file fed one byte per transfer on data_byte (file_start marks
// byte 0 of a new file). Uncompressed (type 2) and run-length (type 10)
// true-colour images of 24 or 32 bits give one span result per pixel or run
// packet, in file order, colour as RGBA; any other format gives one error
// result. The parser takes one byte every cycle while full is low and hands jobs
// to the span generator through a QUEUE_DEPTH-entry queue; full rises only when
// that queue is full. The span generator takes a job only when its output
// register is free or being read, then walks one row at a time through every row
// end the span reaches or crosses before it takes the next job. A result waits
// in an output register while the next bytes keep flowing in.
module tga_rle_pixel_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire logic        file_start,
  input  wire logic        push,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind,
  output logic [15:0]      start_row,
  output logic [15:0]      start_column,
  output logic [7:0]       pixel_count,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic             last_span
);

  logic          in_fire;
  logic          job_push;
  trd_pkg::job_t job_in;
  trd_pkg::job_t job_out;
  logic          q_full;
  logic          q_valid;
  logic          job_take;
  logic          out_valid;

  assign in_fire = push && !full;
  assign full    = q_full;
  assign empty   = !out_valid;

  trd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .data_byte  (data_byte),
    .file_start (file_start),
    .job_push   (job_push),
    .job        (job_in)
  );

  trd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .q_full  (q_full),
    .rd_en   (job_take),
    .rd_job  (job_out),
    .q_valid (q_valid)
  );

  trd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (job_out),
    .job_valid    (q_valid),
    .job_take     (job_take),
    .pop          (pop),
    .out_valid    (out_valid),
    .result_kind  (result_kind),
    .start_row    (start_row),
    .start_column (start_column),
    .pixel_count  (pixel_count),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .image_width  (image_width),
    .image_height (image_height),
    .last_span    (last_span)
  );

endmodule
`default_nettype wire

// File: sv/trd_queue.sv
// short job queue between the byte parser and the span generator
`default_nettype none
module trd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire trd_pkg::job_t wr_job,
  output logic               q_full,
  input  wire logic          rd_en,
  output trd_pkg::job_t      rd_job,
  output logic               q_valid
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trd_pkg::job_t     slots [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign q_full  = (fill == CNT_W'(DEPTH));
  assign q_valid = (fill != '0);
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (!q_full || rd_en)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> q_valid) else $error("queue read while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH)) else $error("queue fill out of range");
`endif

endmodule
`default_nettype wire

// File: sv/trd_front.sv
// byte parser: header, id skip, packet headers and pixel assembly
`default_nettype none
module trd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic [7:0]    data_byte,
  input  wire logic          file_start,
  output logic               job_push,
  output trd_pkg::job_t      job
);

  trd_pkg::phase_t phase, phase_next, cur_phase;
  logic [4:0]  header_index;
  logic [4:0]  cur_hidx;
  logic [7:0]  id_skip_left;
  logic [7:0]  color_map_kind;
  logic [7:0]  image_kind;
  logic [7:0]  bits_per_pixel;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [31:0] pixels_left;
  logic        packet_is_run;
  logic [7:0]  packet_left;
  logic [1:0]  color_byte_index;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  logic [7:0]  red_hold;

  logic        header_done;
  logic        fmt_ok;
  logic        dims_zero;
  logic        is_rle;
  logic        pix_complete;
  logic [7:0]  raw_count;
  logic [7:0]  span_count;
  logic [31:0] pixels_after;
  logic [7:0]  packet_after;
  trd_pkg::phase_t data_phase;

  // a marked first byte restarts the header parse
  assign cur_phase   = file_start ? trd_pkg::PH_HEADER : phase;
  assign cur_hidx    = file_start ? 5'd0 : header_index;
  assign header_done = (cur_hidx == trd_pkg::HDR_LAST);
  assign is_rle      = (image_kind == trd_pkg::IMG_RLE_COLOR);
  assign data_phase  = is_rle ? trd_pkg::PH_PACKET : trd_pkg::PH_PIXEL;
  assign fmt_ok = ((image_kind == trd_pkg::IMG_TRUE_COLOR) || is_rle) &&
                  (color_map_kind == trd_pkg::CMAP_NONE) &&
                  ((bits_per_pixel == trd_pkg::BPP_24) ||
                   (bits_per_pixel == trd_pkg::BPP_32));
  assign dims_zero = (width_reg == 16'd0) || (height_reg == 16'd0);

  assign pix_complete = ((bits_per_pixel == trd_pkg::BPP_24) &&
                         (color_byte_index == trd_pkg::CB_RED)) ||
                        (color_byte_index == trd_pkg::CB_ALPHA);
  assign raw_count  = (is_rle && packet_is_run) ? packet_left : 8'd1;
  assign span_count = (pixels_left < {24'd0, raw_count}) ? pixels_left[7:0] : raw_count;
  assign pixels_after = pixels_left - {24'd0, span_count};
  assign packet_after = (is_rle && packet_is_run) ? 8'd0 :
                        (is_rle ? packet_left - 8'd1 : packet_left);

  always_comb begin
    phase_next = cur_phase;
    unique case (cur_phase)
      trd_pkg::PH_HEADER: begin
        if (header_done) begin
          if (!fmt_ok) begin
            phase_next = trd_pkg::PH_ERROR;
          end else if (dims_zero) begin
            phase_next = trd_pkg::PH_DONE;
          end else if (id_skip_left != 8'd0) begin
            phase_next = trd_pkg::PH_ID_SKIP;
          end else begin
            phase_next = data_phase;
          end
        end
      end
      trd_pkg::PH_ID_SKIP: begin
        if (id_skip_left == 8'd1) begin
          phase_next = data_phase;
        end
      end
      trd_pkg::PH_PACKET: phase_next = trd_pkg::PH_PIXEL;
      trd_pkg::PH_PIXEL: begin
        if (pix_complete) begin
          if (pixels_after == 32'd0) begin
            phase_next = trd_pkg::PH_DONE;
          end else if (is_rle && packet_after == 8'd0) begin
            phase_next = trd_pkg::PH_PACKET;
          end
        end
      end
      trd_pkg::PH_DONE:  phase_next = trd_pkg::PH_DONE;
      trd_pkg::PH_ERROR: phase_next = trd_pkg::PH_ERROR;
      default:           phase_next = trd_pkg::PH_HEADER;
    endcase
  end

  always_comb begin
    job_push = 1'b0;
    job      = '0;
    job.width  = width_reg;
    job.height = height_reg;
    if (in_fire && cur_phase == trd_pkg::PH_HEADER && header_done) begin
      job_push = !fmt_ok || !dims_zero;
      job.kind = fmt_ok ? trd_pkg::JOB_START : trd_pkg::JOB_ERROR;
    end else if (in_fire && cur_phase == trd_pkg::PH_PIXEL && pix_complete) begin
      job_push  = 1'b1;
      job.kind  = trd_pkg::JOB_SPAN;
      job.count = span_count;
      job.blue  = blue_hold;
      job.green = green_hold;
      job.red   = (color_byte_index == trd_pkg::CB_RED) ? data_byte : red_hold;
      job.alpha = (bits_per_pixel == trd_pkg::BPP_24) ? trd_pkg::ALPHA_OPAQUE : data_byte;
      job.last  = (pixels_after == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= trd_pkg::PH_HEADER;
      header_index     <= 5'd0;
      id_skip_left     <= 8'd0;
      color_map_kind   <= 8'd0;
      image_kind       <= 8'd0;
      bits_per_pixel   <= 8'd0;
      width_reg        <= 16'd0;
      height_reg       <= 16'd0;
      pixels_left      <= 32'd0;
      packet_is_run    <= 1'b0;
      packet_left      <= 8'd0;
      color_byte_index <= 2'd0;
    end else if (in_fire) begin
      phase <= phase_next;
      unique case (cur_phase)
        trd_pkg::PH_HEADER: begin
          header_index <= header_done ? 5'd0 : cur_hidx + 5'd1;
          priority case (cur_hidx)
            trd_pkg::HDR_ID_LEN:    id_skip_left      <= data_byte;
            trd_pkg::HDR_CMAP_TYPE: color_map_kind    <= data_byte;
            trd_pkg::HDR_IMG_TYPE:  image_kind        <= data_byte;
            trd_pkg::HDR_WIDTH_LO:  width_reg[7:0]    <= data_byte;
            trd_pkg::HDR_WIDTH_HI:  width_reg[15:8]   <= data_byte;
            trd_pkg::HDR_HEIGHT_LO: height_reg[7:0]   <= data_byte;
            trd_pkg::HDR_HEIGHT_HI: height_reg[15:8]  <= data_byte;
            trd_pkg::HDR_BPP:       bits_per_pixel    <= data_byte;
            default: ;
          endcase
          if (header_done) begin
            pixels_left      <= {16'd0, width_reg} * {16'd0, height_reg};
            packet_left      <= 8'd0;
            packet_is_run    <= 1'b0;
            color_byte_index <= 2'd0;
          end
        end
        trd_pkg::PH_ID_SKIP: id_skip_left <= id_skip_left - 8'd1;
        trd_pkg::PH_PACKET: begin
          packet_is_run    <= data_byte[7];
          packet_left      <= {1'b0, data_byte[6:0]} + 8'd1;
          color_byte_index <= 2'd0;
        end
        trd_pkg::PH_PIXEL: begin
          if (pix_complete) begin
            color_byte_index <= 2'd0;
            packet_left      <= packet_after;
            pixels_left      <= pixels_after;
          end else begin
            color_byte_index <= color_byte_index + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // colour holding registers need no reset
  always_ff @(posedge clk) begin
    if (in_fire && cur_phase == trd_pkg::PH_PIXEL) begin
      unique case (color_byte_index)
        trd_pkg::CB_BLUE:  blue_hold  <= data_byte;
        trd_pkg::CB_GREEN: green_hold <= data_byte;
        trd_pkg::CB_RED:   red_hold   <= data_byte;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_span_nonempty: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.kind == trd_pkg::JOB_SPAN) |-> (job.count != 8'd0))
    else $error("span job with zero count");
  a_pixel_has_work: assert property (@(posedge clk) disable iff (rst)
    (phase == trd_pkg::PH_PIXEL) |-> (pixels_left != 32'd0))
    else $error("pixel phase with no pixels left");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.kind == trd_pkg::JOB_SPAN && job.last && !file_start)
      |=> (phase == trd_pkg::PH_DONE))
    else $error("last span did not end the image");
`endif

endmodule
`default_nettype wire

// File: sv/trd_back.sv
// span generator: tracks row and column and drives the result register
`default_nettype none
module trd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire trd_pkg::job_t job,
  input  wire logic          job_valid,
  output logic               job_take,
  input  wire logic          pop,
  output logic               out_valid,
  output logic               result_kind,
  output logic [15:0]        start_row,
  output logic [15:0]        start_column,
  output logic [7:0]         pixel_count,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic [15:0]        image_width,
  output logic [15:0]        image_height,
  output logic               last_span
);

  logic        busy;
  logic [16:0] acc;
  logic [15:0] cur_row;
  logic [15:0] cur_col;
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic        out_fire;
  logic [16:0] sum;

  assign out_fire = pop && out_valid;
  assign job_take = job_valid && !busy && (!out_valid || out_fire);
  assign sum      = {1'b0, cur_col} + {9'd0, job.count};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        // one row crossing per cycle for spans that reach or cross the row end
        if (acc >= {1'b0, width_reg}) begin
          acc     <= acc - {1'b0, width_reg};
          cur_row <= cur_row - 16'd1;
        end else begin
          cur_col <= acc[15:0];
          busy    <= 1'b0;
        end
      end else if (job_take) begin
        unique case (job.kind)
          trd_pkg::JOB_START: begin
            width_reg  <= job.width;
            height_reg <= job.height;
            cur_row    <= job.height - 16'd1;
            cur_col    <= 16'd0;
          end
          trd_pkg::JOB_SPAN: begin
            out_valid    <= 1'b1;
            result_kind  <= trd_pkg::RES_SPAN;
            start_row    <= cur_row;
            start_column <= cur_col;
            pixel_count  <= job.count;
            red          <= job.red;
            green        <= job.green;
            blue         <= job.blue;
            alpha        <= job.alpha;
            image_width  <= width_reg;
            image_height <= height_reg;
            last_span    <= job.last;
            if (width_reg != 16'd0) begin
              if (sum < {1'b0, width_reg}) begin
                cur_col <= sum[15:0];
              end else begin
                acc     <= sum - {1'b0, width_reg};
                cur_row <= cur_row - 16'd1;
                busy    <= 1'b1;
              end
            end
          end
          trd_pkg::JOB_ERROR: begin
            out_valid    <= 1'b1;
            result_kind  <= trd_pkg::RES_ERROR;
            start_row    <= 16'd0;
            start_column <= 16'd0;
            pixel_count  <= 8'd0;
            red          <= 8'd0;
            green        <= 8'd0;
            blue         <= 8'd0;
            alpha        <= 8'd0;
            image_width  <= job.width;
            image_height <= job.height;
            last_span    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_width: assert property (@(posedge clk) disable iff (rst)
    busy |-> (width_reg != 16'd0)) else $error("row walk with zero width");
  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == trd_pkg::RES_ERROR) |-> (pixel_count == 8'd0 && !last_span))
    else $error("error result carries span fields");
  a_span_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == trd_pkg::RES_SPAN) |-> (pixel_count != 8'd0))
    else $error("span result with zero count");
`endif

endmodule
`default_nettype wire

// File: verif/tga_rle_pixel_decoder_top_tb.sv
// testbench for the tga byte stream decoder: byte files in, spans checked against a predictor
`default_nettype none
module tga_rle_pixel_decoder_top_tb;

  typedef struct {
    logic        kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  count;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [15:0] w;
    logic [15:0] h;
    logic        last;
  } span_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       typed;
    span_t      want;
  } byte_item_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic [7:0]  data_byte;
  logic        file_start;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  logic        result_kind;
  logic [15:0] start_row;
  logic [15:0] start_column;
  logic [7:0]  pixel_count;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        last_span;

  tga_rle_pixel_decoder_top uut (
    .clk(clk), .rst(rst), .data_byte(data_byte), .file_start(file_start),
    .push(push), .full(full), .empty(empty), .pop(pop),
    .result_kind(result_kind), .start_row(start_row), .start_column(start_column),
    .pixel_count(pixel_count), .red(red), .green(green), .blue(blue), .alpha(alpha),
    .image_width(image_width), .image_height(image_height), .last_span(last_span)
  );

  // decoder state mirror
  trd_pkg::phase_t dec_phase;
  logic [4:0]  dec_hdr_idx;
  logic [7:0]  dec_id_left;
  logic [7:0]  dec_cmap;
  logic [7:0]  dec_kind;
  logic [7:0]  dec_bpp;
  logic [15:0] dec_w;
  logic [15:0] dec_h;
  logic [15:0] dec_row;
  logic [15:0] dec_col;
  logic [31:0] dec_left;
  logic        dec_is_run;
  logic [7:0]  dec_pkt_left;
  logic [1:0]  dec_cb;
  logic [7:0]  dec_blue;
  logic [7:0]  dec_green;
  logic [7:0]  dec_red;

  byte_item_t  file_bytes[$];
  span_t       expected_spans[$];
  int          bytes_taken;
  int          spans_seen;
  int          errors_seen;
  int          files_built;
  int          fails;
  int          cycles;
  int          tx_idle;
  int          rx_idle;
  int          hold_asked;
  int          hold_served;
  int          hold_left;

  task automatic clear_decoder();
    dec_phase = trd_pkg::PH_HEADER; dec_hdr_idx = '0; dec_id_left = '0; dec_cmap = '0;
    dec_kind = '0; dec_bpp = '0; dec_w = '0; dec_h = '0; dec_row = '0; dec_col = '0;
    dec_left = '0; dec_is_run = 1'b0; dec_pkt_left = '0; dec_cb = trd_pkg::CB_BLUE;
    dec_blue = '0; dec_green = '0; dec_red = '0;
  endtask

  function automatic trd_pkg::phase_t pixel_phase();
    return (dec_kind == trd_pkg::IMG_RLE_COLOR) ? trd_pkg::PH_PACKET : trd_pkg::PH_PIXEL;
  endfunction

  task automatic decode_byte(input logic [7:0] d, input logic start, output logic got,
                             output span_t s);
    logic [31:0] n;
    logic [31:0] total;
    logic        fine;
    got = 1'b0;
    s = '{default: '0};
    if (start) clear_decoder();
    case (dec_phase)
      trd_pkg::PH_HEADER: begin
        case (dec_hdr_idx)
          trd_pkg::HDR_ID_LEN:    dec_id_left = d;
          trd_pkg::HDR_CMAP_TYPE: dec_cmap = d;
          trd_pkg::HDR_IMG_TYPE:  dec_kind = d;
          trd_pkg::HDR_WIDTH_LO:  dec_w[7:0] = d;
          trd_pkg::HDR_WIDTH_HI:  dec_w[15:8] = d;
          trd_pkg::HDR_HEIGHT_LO: dec_h[7:0] = d;
          trd_pkg::HDR_HEIGHT_HI: dec_h[15:8] = d;
          trd_pkg::HDR_BPP:       dec_bpp = d;
          default: ;
        endcase
        if (dec_hdr_idx != trd_pkg::HDR_LAST) begin
          dec_hdr_idx = dec_hdr_idx + 1'b1;
        end else begin
          dec_hdr_idx = '0;
          fine = (dec_kind == trd_pkg::IMG_TRUE_COLOR || dec_kind == trd_pkg::IMG_RLE_COLOR) &&
                 dec_cmap == trd_pkg::CMAP_NONE &&
                 (dec_bpp == trd_pkg::BPP_24 || dec_bpp == trd_pkg::BPP_32);
          if (!fine) begin
            dec_phase = trd_pkg::PH_ERROR;
            got = 1'b1;
            s.kind = trd_pkg::RES_ERROR; s.w = dec_w; s.h = dec_h;
          end else begin
            dec_left = {16'd0, dec_w} * {16'd0, dec_h};
            dec_row = dec_h - 1'b1;
            dec_col = '0; dec_pkt_left = '0; dec_is_run = 1'b0; dec_cb = trd_pkg::CB_BLUE;
            if (dec_left == 0) dec_phase = trd_pkg::PH_DONE;
            else if (dec_id_left != 0) dec_phase = trd_pkg::PH_ID_SKIP;
            else dec_phase = pixel_phase();
          end
        end
      end
      trd_pkg::PH_ID_SKIP: begin
        dec_id_left = dec_id_left - 1'b1;
        if (dec_id_left == 0) dec_phase = pixel_phase();
      end
      trd_pkg::PH_PACKET: begin
        dec_is_run = d[7];
        dec_pkt_left = {1'b0, d[6:0]} + 8'd1;
        dec_cb = trd_pkg::CB_BLUE;
        dec_phase = trd_pkg::PH_PIXEL;
      end
      trd_pkg::PH_PIXEL: begin
        case (dec_cb)
          trd_pkg::CB_BLUE:  dec_blue = d;
          trd_pkg::CB_GREEN: dec_green = d;
          trd_pkg::CB_RED:   dec_red = d;
          default: ;
        endcase
        if (!((dec_bpp == trd_pkg::BPP_24 && dec_cb == trd_pkg::CB_RED) ||
              dec_cb == trd_pkg::CB_ALPHA)) begin
          dec_cb = dec_cb + 1'b1;
        end else begin
          dec_cb = trd_pkg::CB_BLUE;
          if (dec_kind == trd_pkg::IMG_RLE_COLOR && dec_is_run) begin
            n = {24'd0, dec_pkt_left};
            dec_pkt_left = '0;
          end else begin
            n = 32'd1;
            if (dec_kind == trd_pkg::IMG_RLE_COLOR) dec_pkt_left = dec_pkt_left - 1'b1;
          end
          if (n > dec_left) n = dec_left;
          s.row = dec_row; s.col = dec_col; s.count = n[7:0];
          total = {16'd0, dec_col} + n;
          dec_col = 16'(total % {16'd0, dec_w});
          dec_row = dec_row - 16'(total / {16'd0, dec_w});
          dec_left = dec_left - n;
          if (dec_left == 0) begin
            dec_phase = trd_pkg::PH_DONE;
            s.last = 1'b1;
          end else if (dec_kind == trd_pkg::IMG_RLE_COLOR && dec_pkt_left == 0) begin
            dec_phase = trd_pkg::PH_PACKET;
          end
          s.kind = trd_pkg::RES_SPAN; s.r = dec_red; s.g = dec_green; s.b = dec_blue;
          s.a = (dec_bpp == trd_pkg::BPP_24) ? trd_pkg::ALPHA_OPAQUE : d;
          s.w = dec_w; s.h = dec_h;
          got = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic add_byte(input logic [7:0] d, input logic start);
    byte_item_t it;
    it.data = d; it.start = start; it.typed = 1'b0; it.want = '{default: '0};
    file_bytes = {file_bytes, it};
  endtask

  task automatic add_header(input logic [7:0] id_len, input logic [7:0] cmap,
                            input logic [7:0] kind, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] bpp, input logic start);
    add_byte(id_len, start);
    add_byte(cmap, 1'b0);
    add_byte(kind, 1'b0);
    for (int i = 3; i < 12; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    add_byte(w[7:0], 1'b0);
    add_byte(w[15:8], 1'b0);
    add_byte(h[7:0], 1'b0);
    add_byte(h[15:8], 1'b0);
    add_byte(bpp, 1'b0);
    add_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic add_pixel(input int nbytes);
    for (int i = 0; i < nbytes; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // one random file, mostly well formed with random content
  task automatic add_random_file();
    int          pick;
    int          id_len;
    int          px_bytes;
    int          remaining;
    int          n;
    logic [7:0]  kind;
    logic [7:0]  cmap;
    logic [7:0]  bpp;
    logic [7:0]  pkt;
    logic [15:0] w;
    logic [15:0] h;
    logic        start;
    pick = $urandom_range(0, 99);
    start = ($urandom_range(0, 99) < 96);
    id_len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
    kind = $urandom_range(0, 1) ? trd_pkg::IMG_RLE_COLOR : trd_pkg::IMG_TRUE_COLOR;
    cmap = trd_pkg::CMAP_NONE;
    bpp = $urandom_range(0, 1) ? trd_pkg::BPP_32 : trd_pkg::BPP_24;
    w = 16'($urandom_range(1, 8));
    h = 16'($urandom_range(1, 4));
    files_built++;
    if (pick < 10) begin
      case ($urandom_range(0, 2))
        0: kind = 8'($urandom_range(0, 255));
        1: cmap = 8'($urandom_range(1, 255));
        default: bpp = 8'($urandom_range(0, 255));
      endcase
      add_header(8'(id_len), cmap, kind, 16'($urandom), 16'($urandom), bpp, start);
      add_pixel($urandom_range(0, 4));
      return;
    end
    if (pick < 15) begin
      if ($urandom_range(0, 1)) w = 0; else h = 0;
      if ($urandom_range(0, 1)) begin
        w = w ? 16'hffff : w;
        h = h ? 16'hffff : h;
      end
      add_header(8'(id_len), cmap, kind, w, h, bpp, start);
      add_pixel($urandom_range(0, 4));
      return;
    end
    if (pick < 20) begin
      // huge image cut short by the next file
      w = $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(200, 65535));
      h = $urandom_range(0, 1) ? 16'hffff : 16'($urandom_range(1, 65535));
      add_header(8'(id_len), cmap, kind, w, h, bpp, start);
      add_pixel(id_len);
      for (int i = 0; i < 6; i++) begin
        if (kind == trd_pkg::IMG_RLE_COLOR) add_byte($urandom_range(0, 1) ? 8'hff : 8'h7f, 1'b0);
        add_pixel(bpp / 8);
      end
      return;
    end
    if (pick < 30) w = 16'($urandom_range(1, 3));
    add_header(8'(id_len), cmap, kind, w, h, bpp, start);
    add_pixel(id_len);
    px_bytes = bpp / 8;
    remaining = w * h;
    if (kind == trd_pkg::IMG_TRUE_COLOR) begin
      add_pixel(remaining * px_bytes);
    end else begin
      while (remaining > 0) begin
        pkt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
            : {1'($urandom_range(0, 1)), 7'($urandom_range(0, 6))};
        add_byte(pkt, 1'b0);
        n = pkt[6:0] + 1;
        if (pkt[7]) add_pixel(px_bytes);
        else add_pixel((n < remaining ? n : remaining) * px_bytes);
        remaining -= n;
      end
    end
    // sometimes cut the file short, sometimes trailing junk
    if ($urandom_range(0, 9) == 0 && file_bytes.size() > 0) void'(file_bytes.pop_back());
    add_pixel($urandom_range(0, 3));
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // transfer monitor: predict on each byte taken, check on each result taken
  always @(posedge clk) begin
    logic  got;
    span_t s;
    span_t e;
    if (!rst && push && !full) begin
      byte_item_t it;
      it = file_bytes[bytes_taken];
      decode_byte(data_byte, file_start, got, s);
      if (it.typed) begin
        expected_spans = {expected_spans, it.want};
      end else if (got) begin
        expected_spans = {expected_spans, s};
      end
      bytes_taken = bytes_taken + 1;
    end
    if (!rst && pop && !empty) begin
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected result, kind %0d row %0d col %0d", $time,
                 result_kind, start_row, start_column);
        fails++;
      end else begin
        e = expected_spans.pop_front();
        check_field("result_kind", 16'(e.kind), 16'(result_kind));
        check_field("start_row", e.row, start_row);
        check_field("start_column", e.col, start_column);
        check_field("pixel_count", 16'(e.count), 16'(pixel_count));
        check_field("red", 16'(e.r), 16'(red));
        check_field("green", 16'(e.g), 16'(green));
        check_field("blue", 16'(e.b), 16'(blue));
        check_field("alpha", 16'(e.a), 16'(alpha));
        check_field("image_width", e.w, image_width);
        check_field("image_height", e.h, image_height);
        check_field("last_span", 16'(e.last), 16'(last_span));
      end
      if (result_kind == trd_pkg::RES_ERROR) errors_seen++;
      else spans_seen++;
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  initial begin
    int n_directed;
    int target;
    int phase_len;
    rst = 1'b1; push = 1'b0; data_byte = '0; file_start = 1'b0;
    fails = 0; cycles = 0; bytes_taken = 0; spans_seen = 0; errors_seen = 0;
    files_built = 0; hold_asked = 0; hold_served = 0; hold_left = 0;
    tx_idle = 14; rx_idle = 76;
    clear_decoder();

    // directed: header with no start mark and an unknown image type, then ignored bytes
    add_header(8'd0, trd_pkg::CMAP_NONE, 8'd3, 16'd5, 16'd2, trd_pkg::BPP_24, 1'b0);
    file_bytes[file_bytes.size() - 1].typed = 1'b1;
    file_bytes[file_bytes.size() - 1].want =
      '{kind: trd_pkg::RES_ERROR, w: 16'd5, h: 16'd2, default: '0};
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h7f, 1'b0);
    // 1x1 32-bit image with all-ones colour
    add_header(8'd0, trd_pkg::CMAP_NONE, trd_pkg::IMG_TRUE_COLOR, 16'd1, 16'd1,
               trd_pkg::BPP_32, 1'b1);
    for (int i = 0; i < 4; i++) add_byte(8'hff, 1'b0);
    file_bytes[file_bytes.size() - 1].typed = 1'b1;
    file_bytes[file_bytes.size() - 1].want = '{kind: trd_pkg::RES_SPAN, count: 8'd1,
      r: 8'hff, g: 8'hff, b: 8'hff, a: 8'hff, w: 16'd1, h: 16'd1, last: 1'b1,
      default: '0};
    n_directed = file_bytes.size();
    while (file_bytes.size() < n_directed + 1500) add_random_file();
    phase_len = file_bytes.size() / 3;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < file_bytes.size(); i++) begin
      if (i == phase_len) begin
        tx_idle = 76; rx_idle = 14;
      end else if (i == 2 * phase_len) begin
        tx_idle = 0; rx_idle = 0;
        hold_asked = hold_asked + 1;
      end
      while ($urandom_range(0, 99) < tx_idle) begin
        push <= 1'b0;
        @(negedge clk);
      end
      push <= 1'b1;
      data_byte <= file_bytes[i].data;
      file_start <= file_bytes[i].start;
      target = i + 1;
      // the monitor has settled by the falling edge
      @(negedge clk);
      while (bytes_taken < target) @(negedge clk);
    end
    push <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d files; %0d spans and %0d format errors checked",
             bytes_taken, files_built + 2, spans_seen, errors_seen);
    if (expected_spans.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_spans.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
